### design/lpfb_pkg.sv
package lpfb_pkg;

   // strip geometry
   localparam int MAX_LEDS_DEFAULT = 256;
   localparam int MAX_LEDS_LIMIT   = 4096;
   localparam int CMD_AW           = 12;   // address field wide enough for the largest strip
   localparam int CMD_LW           = 13;   // length field wide enough for the largest strip
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [8:0] ACTIVE_RESET = 9'd256;
   localparam logic [4:0] LEVEL_MAX    = 5'h1F;
   localparam logic [7:0] FRAME_MARK   = 8'hE0;

   // request kinds
   localparam logic [3:0] KIND_SET_PIXEL  = 4'd0;
   localparam logic [3:0] KIND_SET_COLOR  = 4'd1;
   localparam logic [3:0] KIND_SET_LEVEL  = 4'd2;
   localparam logic [3:0] KIND_READ       = 4'd3;
   localparam logic [3:0] KIND_FILL_BOTH  = 4'd4;
   localparam logic [3:0] KIND_FILL_COLOR = 4'd5;
   localparam logic [3:0] KIND_FILL_LEVEL = 4'd6;
   localparam logic [3:0] KIND_CLEAR      = 4'd7;
   localparam logic [3:0] KIND_PUSH_FRONT = 4'd8;
   localparam logic [3:0] KIND_PUSH_BACK  = 4'd9;
   localparam logic [3:0] KIND_ROT_LEFT   = 4'd10;
   localparam logic [3:0] KIND_ROT_RIGHT  = 4'd11;

   // engine operations
   localparam logic [2:0] OP_NOP    = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_FILL   = 3'd2;
   localparam logic [2:0] OP_COLOR  = 3'd3;
   localparam logic [2:0] OP_LEVEL  = 3'd4;
   localparam logic [2:0] OP_SHIFT  = 3'd5;
   localparam logic [2:0] OP_ROTATE = 3'd6;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] level;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [4:0] level_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [4:0] level;
   } pixel_type;

   localparam pixel_type PIXEL_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0, level: LEVEL_MAX};

   typedef struct packed {
      logic [2:0]        op;
      logic              down;
      logic [CMD_AW-1:0] first;
      logic [CMD_LW-1:0] count;
      pixel_type         px;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } eng_status_type;

   function automatic logic [4:0] sat_level(input logic [7:0] lvl);
      return (lvl > 8'(LEVEL_MAX)) ? LEVEL_MAX : lvl[4:0];
   endfunction

   // header byte sent ahead of a pixel on the wire
   function automatic logic [7:0] frame_byte(input logic [4:0] lvl);
      return FRAME_MARK | {3'b000, lvl};
   endfunction

endpackage

### design/lpfb_queue.sv
module lpfb_queue
   import lpfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'(QUEUE_DEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/lpfb_front.sv
module lpfb_front
   import lpfb_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  req_type        req_data,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [8:0]     csr_data,
   input  logic           q_full,
   input  eng_status_type eng_status,
   output logic           push,
   output cmd_type        push_cmd
);

   localparam int LW = $clog2(MAX_LEDS + 1);
   localparam int CW = (LW > 9) ? LW : 9;

   logic [8:0]    active_ff, active_in;
   logic [CW-1:0] act_ext;
   logic [LW-1:0] live_len;
   logic          in_range;
   logic          bulk_ok;
   pixel_type     fresh;

   assign csr_ready = 1'b1;
   assign busy      = q_full | eng_status.clearing;
   assign push      = start & ~busy;

   always_comb begin
      active_in = (csr_valid & csr_ready) ? csr_data : active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   // active length saturated to the store size
   assign act_ext  = CW'(active_ff);
   assign live_len = (act_ext > CW'(MAX_LEDS)) ? LW'(MAX_LEDS) : LW'(act_ext);
   assign in_range = CW'(req_data.index) < CW'(live_len);
   assign bulk_ok  = (live_len != LW'(0));

   always_comb begin
      fresh = '{red: req_data.red, green: req_data.green, blue: req_data.blue,
                level: sat_level(req_data.level)};
      push_cmd       = '0;
      push_cmd.px    = fresh;
      push_cmd.op    = OP_NOP;
      push_cmd.down  = 1'b0;
      push_cmd.first = CMD_AW'(0);
      push_cmd.count = CMD_LW'(live_len);
      unique case (req_data.kind) inside
         KIND_SET_PIXEL, KIND_SET_COLOR, KIND_SET_LEVEL, KIND_READ: begin
            push_cmd.first = CMD_AW'(req_data.index);
            push_cmd.count = CMD_LW'(1);
            if (in_range) begin
               unique case (req_data.kind)
                  KIND_SET_PIXEL: push_cmd.op = OP_FILL;
                  KIND_SET_COLOR: push_cmd.op = OP_COLOR;
                  KIND_SET_LEVEL: push_cmd.op = OP_LEVEL;
                  default:        push_cmd.op = OP_READ;
               endcase
            end
         end
         KIND_FILL_BOTH: begin
            if (bulk_ok) push_cmd.op = OP_FILL;
         end
         KIND_FILL_COLOR: begin
            if (bulk_ok) push_cmd.op = OP_COLOR;
         end
         KIND_FILL_LEVEL: begin
            if (bulk_ok) push_cmd.op = OP_LEVEL;
         end
         KIND_CLEAR: begin
            push_cmd.px = PIXEL_BLACK;
            if (bulk_ok) push_cmd.op = OP_FILL;
         end
         KIND_PUSH_FRONT, KIND_ROT_RIGHT: begin
            // walk from the last active pixel down to pixel 0
            push_cmd.down  = 1'b1;
            push_cmd.first = CMD_AW'(live_len - LW'(1));
            if (bulk_ok) begin
               push_cmd.op = (req_data.kind == KIND_PUSH_FRONT) ? OP_SHIFT : OP_ROTATE;
            end
         end
         KIND_PUSH_BACK, KIND_ROT_LEFT: begin
            if (bulk_ok) begin
               push_cmd.op = (req_data.kind == KIND_PUSH_BACK) ? OP_SHIFT : OP_ROTATE;
            end
         end
         default: begin
            push_cmd.op = OP_NOP;
         end
      endcase
   end

endmodule

### design/lpfb_engine.sv
module lpfb_engine
   import lpfb_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  cmd_type        head_cmd,
   output logic           pop,
   output eng_status_type eng_status,
   output logic           rsp_valid,
   output rsp_type        rsp_data
);

   localparam int AW = $clog2(MAX_LEDS);
   localparam int LW = $clog2(MAX_LEDS + 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_PREP  = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_RUN   = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;

   pixel_type     mem [MAX_LEDS];
   pixel_type     mem_rd_ff;

   logic [2:0]    state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [LW-1:0] remain_ff, remain_in;
   pixel_type     fresh_ff, fresh_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_last_ff, s1_last_in;
   logic [AW-1:0] s1_addr_ff, s1_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          moves;
   logic [AW-1:0] ptr_step;
   logic [AW-1:0] rd_addr;
   logic          clear_wr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   pixel_type     wr_data;
   pixel_type     merged;

   assign eng_status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign moves    = (cmd_ff.op == OP_SHIFT) || (cmd_ff.op == OP_ROTATE);
   assign ptr_step = cmd_ff.down ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ptr_in       = ptr_ff;
      remain_in    = remain_ff;
      fresh_in     = fresh_ff;
      s1_valid_in  = 1'b0;
      s1_last_in   = (remain_ff == LW'(1));
      s1_addr_in   = ptr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rd_addr      = ptr_ff;
      clear_wr     = 1'b0;
      pop          = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_wr = 1'b1;
            ptr_in   = ptr_ff + AW'(1);
            if (ptr_ff == AW'(MAX_LEDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop       = 1'b1;
               cmd_in    = head_cmd;
               ptr_in    = head_cmd.first[AW-1:0];
               remain_in = head_cmd.count[LW-1:0];
               fresh_in  = head_cmd.px;
               if (head_cmd.op == OP_NOP) begin
                  rsp_valid_in = 1'b1;
               end else if (head_cmd.op == OP_ROTATE) begin
                  state_in = ST_PREP;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_PREP: begin
            // fetch the pixel that wraps around
            rd_addr  = ptr_ff;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            fresh_in = mem_rd_ff;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rd_addr     = moves ? ptr_step : ptr_ff;
            s1_valid_in = 1'b1;
            ptr_in      = ptr_step;
            remain_in   = remain_ff - LW'(1);
            if (remain_ff == LW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            if (cmd_ff.op == OP_READ) begin
               rsp_in = '{hit: 1'b1, red_out: mem_rd_ff.red, green_out: mem_rd_ff.green,
                          blue_out: mem_rd_ff.blue, level_out: mem_rd_ff.level};
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // write stage picks the pixel to store from the fetched pixel, the request pixel or a mix
   always_comb begin
      case (cmd_ff.op)
         OP_COLOR:  merged = '{red: fresh_ff.red, green: fresh_ff.green,
                              blue: fresh_ff.blue, level: mem_rd_ff.level};
         OP_LEVEL:  merged = '{red: mem_rd_ff.red, green: mem_rd_ff.green,
                              blue: mem_rd_ff.blue, level: fresh_ff.level};
         OP_SHIFT,
         OP_ROTATE: merged = s1_last_ff ? fresh_ff : mem_rd_ff;
         default:   merged = fresh_ff;
      endcase
   end

   assign wr_en   = clear_wr | (s1_valid_ff & (cmd_ff.op != OP_READ));
   assign wr_addr = clear_wr ? ptr_ff : s1_addr_ff;
   assign wr_data = clear_wr ? PIXEL_BLACK : merged;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      remain_ff  <= remain_in;
      fresh_ff   <= fresh_in;
      s1_last_ff <= s1_last_in;
      s1_addr_ff <= s1_addr_in;
      rsp_ff     <= rsp_in;
   end

endmodule

### design/led_pixel_frame_buffer.sv
// flow: per-pixel requests and reads answer after the run and drain states, no-ops straight
// from idle; whole-strip fills and pushes walk the active length, rotations first fetch the
// wrapping pixel; the single write port of the pixel memory takes one pixel per cycle
// queueing: one request runs at a time; a 2-entry queue lets requests wait while one runs
// reset: synchronous; the pixel memory is then swept to black at brightness 31 while busy
// stays high; results are a one-cycle strobe and cannot be stalled
module led_pixel_frame_buffer
   import lpfb_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   // result channel
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   // active length register
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_data
);

   // front to queue
   logic           push;
   cmd_type        push_cmd;
   logic           q_full;

   // queue to engine
   logic           head_valid;
   cmd_type        head_cmd;
   logic           pop;

   // engine status back to the front
   eng_status_type eng_status;

   // front: holds the active length, decodes each request into an engine command
   // (operation, start position, pixel count, direction, fresh pixel)
   lpfb_front #(
      .MAX_LEDS(MAX_LEDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .eng_status (eng_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // short command queue decoupling decode from execution
   lpfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // engine: pixel memory with a read stage and a write stage, one pixel per cycle
   lpfb_engine #(
      .MAX_LEDS(MAX_LEDS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .eng_status (eng_status),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

### bench/tb_led_pixel_frame_buffer.sv
module tb_led_pixel_frame_buffer;
   timeunit 1ns;
   timeprecision 1ps;

   import lpfb_pkg::*;

   localparam int PIXEL_COUNT    = 256;
   localparam int REPORT_LIMIT   = 10;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 20;

   // kinds the block leaves alone
   localparam logic [3:0] KIND_UNUSED_LO = 4'd12;
   localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

   // shadow of the pixel memory, predicts one response per request
   class pixel_scoreboard;
      pixel_type  pixels[PIXEL_COUNT];
      logic [8:0] active_len;
      rsp_type    expected_q[$];
      int         errors;

      function new();
         foreach (pixels[i]) pixels[i] = PIXEL_BLACK;
         active_len = ACTIVE_RESET;
         errors = 0;
      endfunction

      function void set_active(logic [8:0] value);
         active_len = value;
      endfunction

      // register value clipped to the memory size
      function int live_len();
         return (int'(active_len) > PIXEL_COUNT) ? PIXEL_COUNT : int'(active_len);
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function void move_toward_back(int n, pixel_type fresh);
         for (int i = n - 1; i > 0; i--) pixels[i] = pixels[i - 1];
         if (n > 0) pixels[0] = fresh;
      endfunction

      function void move_toward_front(int n, pixel_type fresh);
         for (int i = 0; i < n - 1; i++) pixels[i] = pixels[i + 1];
         if (n > 0) pixels[n - 1] = fresh;
      endfunction

      function void apply_request(req_type rq);
         int         n;
         logic [4:0] lvl;
         logic       in_range;
         pixel_type  fresh;
         rsp_type    res;
         n = live_len();
         lvl = (rq.level > 8'(LEVEL_MAX)) ? LEVEL_MAX : rq.level[4:0];
         in_range = int'(rq.index) < n;
         fresh = '{red: rq.red, green: rq.green, blue: rq.blue, level: lvl};
         res = '0;
         case (rq.kind)
            KIND_SET_PIXEL: if (in_range) pixels[rq.index] = fresh;
            KIND_SET_COLOR: if (in_range) begin
               fresh.level = pixels[rq.index].level;
               pixels[rq.index] = fresh;
            end
            KIND_SET_LEVEL: if (in_range) pixels[rq.index].level = lvl;
            KIND_READ: if (in_range) begin
               res.hit       = 1'b1;
               res.red_out   = pixels[rq.index].red;
               res.green_out = pixels[rq.index].green;
               res.blue_out  = pixels[rq.index].blue;
               res.level_out = pixels[rq.index].level;
            end
            KIND_FILL_BOTH: for (int i = 0; i < n; i++) pixels[i] = fresh;
            KIND_FILL_COLOR: for (int i = 0; i < n; i++) begin
               pixels[i].red   = rq.red;
               pixels[i].green = rq.green;
               pixels[i].blue  = rq.blue;
            end
            KIND_FILL_LEVEL: for (int i = 0; i < n; i++) pixels[i].level = lvl;
            KIND_CLEAR: for (int i = 0; i < n; i++) pixels[i] = PIXEL_BLACK;
            KIND_PUSH_FRONT: move_toward_back(n, fresh);
            KIND_PUSH_BACK: move_toward_front(n, fresh);
            KIND_ROT_LEFT: if (n > 0) move_toward_front(n, pixels[0]);
            KIND_ROT_RIGHT: if (n > 0) move_toward_back(n, pixels[n - 1]);
            default: ;
         endcase
         expected_q.push_back(res);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected response hit=%0b rgb=%h/%h/%h level=%h",
                        got.hit, got.red_out, got.green_out, got.blue_out, got.level_out);
            return;
         end
         want = expected_q.pop_front();
         if (got.hit !== want.hit || got.red_out !== want.red_out ||
             got.green_out !== want.green_out || got.blue_out !== want.blue_out ||
             got.level_out !== want.level_out) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("response mismatch: expected hit=%0b rgb=%h/%h/%h level=%h, got hit=%0b rgb=%h/%h/%h level=%h",
                        want.hit, want.red_out, want.green_out, want.blue_out, want.level_out,
                        got.hit, got.red_out, got.green_out, got.blue_out, got.level_out);
         end
      endfunction

      // leftovers count against the run
      function int total_errors();
         return errors + expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [8:0] csr_data = '0;

   pixel_scoreboard sb;
   int              burst_left = 0;
   int              idle_cycles = 0;

   // active lengths walked through by the random phases, extremes included
   int phase_lens[12] = '{2, 3, 5, 8, 16, 511, 1, 0, 12, 256, 7, 300};

   led_pixel_frame_buffer #(.MAX_LEDS(PIXEL_COUNT)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // every response strobe is checked at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_result(rsp_data);
   end

   // stall detector: resets on any handshake or response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic req_type make_request(logic [3:0] kind, logic [7:0] index,
                                            logic [7:0] red, logic [7:0] green,
                                            logic [7:0] blue, logic [7:0] level);
      req_type rq;
      rq = '{kind: kind, index: index, red: red, green: green, blue: blue, level: level};
      return rq;
   endfunction

   // mostly in-range pixel traffic with reads mixed in, some bulk work and noise
   function automatic req_type random_request(int n);
      req_type rq;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 22)      rq.kind = KIND_READ;
      else if (pick < 38) rq.kind = KIND_SET_PIXEL;
      else if (pick < 46) rq.kind = KIND_SET_COLOR;
      else if (pick < 54) rq.kind = KIND_SET_LEVEL;
      else if (pick < 59) rq.kind = KIND_FILL_BOTH;
      else if (pick < 64) rq.kind = KIND_FILL_COLOR;
      else if (pick < 69) rq.kind = KIND_FILL_LEVEL;
      else if (pick < 72) rq.kind = KIND_CLEAR;
      else if (pick < 79) rq.kind = KIND_PUSH_FRONT;
      else if (pick < 86) rq.kind = KIND_PUSH_BACK;
      else if (pick < 91) rq.kind = KIND_ROT_LEFT;
      else if (pick < 96) rq.kind = KIND_ROT_RIGHT;
      else                rq.kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      // one index in five may land anywhere, out of range included
      if (n > 0 && $urandom_range(0, 4) != 0) rq.index = 8'($urandom_range(0, n - 1));
      else rq.index = 8'($urandom_range(0, 255));
      rq.red   = 8'($urandom);
      rq.green = 8'($urandom);
      rq.blue  = 8'($urandom);
      // half the levels in range, half that saturate or not
      rq.level = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 31)) : 8'($urandom);
      return rq;
   endfunction

   // called and left at a falling edge; bursts of requests with random gaps
   task automatic send_request(req_type rq);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      start    <= 1'b1;
      req_data <= rq;
      // request taken at a rising edge with busy low
      do @(posedge clock); while (busy !== 1'b0);
      sb.apply_request(rq);
      burst_left--;
      @(negedge clock);
   endtask

   // register write only once every response is back
   task automatic write_active(logic [8:0] value);
      start <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_active(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int n;
      int count;
      sb = new();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: full length from reset
      send_request(make_request(KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_request(KIND_SET_PIXEL, 8'd255, 8'hFF, 8'h00, 8'hFF, 8'hFF));
      send_request(make_request(KIND_READ, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00));
      // color only keeps the stored level
      send_request(make_request(KIND_SET_COLOR, 8'd255, 8'h00, 8'hFF, 8'h00, 8'h00));
      // level only keeps the stored color, 32 saturates
      send_request(make_request(KIND_SET_LEVEL, 8'd255, 8'h00, 8'h00, 8'h00, 8'd32));
      send_request(make_request(KIND_READ, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_request(KIND_FILL_BOTH, 8'd0, 8'h12, 8'h34, 8'h56, 8'd7));
      send_request(make_request(KIND_FILL_COLOR, 8'd0, 8'hAA, 8'hBB, 8'hCC, 8'd0));
      send_request(make_request(KIND_FILL_LEVEL, 8'd0, 8'h00, 8'h00, 8'h00, 8'd0));
      send_request(make_request(KIND_PUSH_FRONT, 8'd0, 8'h01, 8'h02, 8'h03, 8'hFF));
      send_request(make_request(KIND_PUSH_BACK, 8'd0, 8'h04, 8'h05, 8'h06, 8'd31));
      send_request(make_request(KIND_ROT_LEFT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_request(KIND_ROT_RIGHT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_request(KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_request(KIND_READ, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00));
      // unused kinds answer all zero
      send_request(make_request(KIND_UNUSED_LO, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_request(KIND_UNUSED_HI, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_request(KIND_CLEAR, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_request(KIND_READ, 8'd128, 8'h00, 8'h00, 8'h00, 8'h00));

      // single pixel: push overwrites pixel 0, rotation is a no-op
      write_active(9'd1);
      send_request(make_request(KIND_PUSH_BACK, 8'd0, 8'h55, 8'h66, 8'h77, 8'd9));
      send_request(make_request(KIND_ROT_RIGHT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_request(KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_request(KIND_READ, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_request(KIND_SET_PIXEL, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'd5));

      // zero length: nothing changes, reads miss
      write_active(9'd0);
      send_request(make_request(KIND_SET_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd3));
      send_request(make_request(KIND_FILL_BOTH, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd3));
      send_request(make_request(KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));

      // random phases, fixed lengths then a few random short ones
      for (int p = 0; p < 16; p++) begin
         if (p < 12) write_active(9'(phase_lens[p]));
         else write_active(9'($urandom_range(1, 32)));
         n = sb.live_len();
         // long strips are slow, keep their phases short
         count = (n >= 64) ? 40 : ((n == 0) ? 60 : 125);
         for (int k = 0; k < count; k++) send_request(random_request(n));
      end

      // drain, then give stray responses time to show up
      start <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (sb.total_errors() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
design/lpfb_pkg.sv
design/lpfb_queue.sv
design/lpfb_front.sv
design/lpfb_engine.sv
design/led_pixel_frame_buffer.sv
bench/tb_led_pixel_frame_buffer.sv
